// ===== rtl/fpsa_pkg.sv =====
// Shared types and constants for the free page stack allocator.
// No dependencies; used by every other file in rtl/ except fpsa_ram.
package fpsa_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SPAN_W   = 5;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned POOL_PAGES_DEF = 4096;
  localparam int unsigned PAGE_SHIFT_DEF = 12;
  localparam int unsigned MAX_SPAN_DEF   = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_FREE       = 2'd1,
    CMD_FREE_RANGE = 2'd2,
    CMD_SPAN       = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_RANGE,
    S_SCAN,
    S_MARK
  } state_e;

  typedef struct packed {
    logic              clr;
    logic              vld;
    logic [SPAN_W-1:0] len;
  } span_ctl_t;

endpackage

// ===== rtl/fpsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fpsa_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fpsa_span.sv =====
// Run tracker for span alloc: follows the slot stream read from the stack
// and latches the first run of consecutive untaken frames of the wanted length.
// Depends on fpsa_pkg.
module fpsa_span #(
  parameter int unsigned IDX_W   = 12,
  parameter int unsigned FRAME_W = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fpsa_pkg::span_ctl_t   ctl_i,
  input  logic                  taken_i,
  input  logic [FRAME_W-1:0]    frame_i,
  input  logic [IDX_W-1:0]      idx_i,
  output logic                  found_o,
  output logic [IDX_W-1:0]      base_idx_o,
  output logic [FRAME_W-1:0]    base_frame_o
);

  logic [fpsa_pkg::SPAN_W-1:0] run_q, run_d;
  logic [FRAME_W-1:0]          prev_q, prev_d;
  logic [IDX_W-1:0]            base_idx_q, base_idx_d;
  logic [FRAME_W-1:0]          base_frame_q, base_frame_d;
  logic                        found_q, found_d;
  logic                        chain;
  logic [fpsa_pkg::SPAN_W-1:0] run_nx;

  // frame numbers never wrap, so compare one bit wider
  assign chain = (run_q != '0) && ({1'b0, frame_i} == ({1'b0, prev_q} + 1'b1));

  always_comb begin
    run_d        = run_q;
    prev_d       = prev_q;
    base_idx_d   = base_idx_q;
    base_frame_d = base_frame_q;
    found_d      = found_q;
    run_nx       = chain ? run_q + 1'b1 : fpsa_pkg::SPAN_W'(1);
    if (ctl_i.clr) begin
      run_d   = '0;
      found_d = 1'b0;
    end else if (ctl_i.vld && !found_q) begin
      prev_d = frame_i;
      if (taken_i) begin
        run_d = '0;
      end else begin
        run_d = run_nx;
        if (!chain) begin
          base_idx_d   = idx_i;
          base_frame_d = frame_i;
        end
        found_d = (run_nx == ctl_i.len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      found_q <= 1'b0;
    end else begin
      run_q   <= run_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q       <= prev_d;
    base_idx_q   <= base_idx_d;
    base_frame_q <= base_frame_d;
  end

  assign found_o      = found_q;
  assign base_idx_o   = base_idx_q;
  assign base_frame_o = base_frame_q;

endmodule

// ===== rtl/free_page_stack_allocator.sv =====
// Free page frame stack allocator, one pool. Depends on fpsa_pkg, fpsa_ram, fpsa_span.
//
// An item is taken when start is high and busy is low; its one result appears on
// status_o/page_addr_o with done_o high for a single cycle and must be captured then.
// All slots live in one RAM with registered read data. free pushes its frame directly;
// alloc pops slots from the top until one is untaken or the stack is empty (taken slots
// are dropped on the way); free-range pushes one page at a time; span alloc streams one
// slot read per cycle from the bottom of the stack, then writes the slot of each page in
// the run to mark it taken. busy stays low in the cycle that shows a result, so the next
// item may be taken there.
module free_page_stack_allocator #(
  parameter int unsigned POOL_PAGES = fpsa_pkg::POOL_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = fpsa_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned MAX_SPAN   = fpsa_pkg::MAX_SPAN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [fpsa_pkg::CMD_W-1:0]        cmd_i,
  input  logic [fpsa_pkg::ADDR_W-1:0]       addr_i,
  input  logic [fpsa_pkg::ADDR_W-1:0]       end_addr_i,
  input  logic [fpsa_pkg::SPAN_W-1:0]       span_pages_i,
  output logic                              done_o,
  output logic [fpsa_pkg::STATUS_W-1:0]     status_o,
  output logic [fpsa_pkg::ADDR_W-1:0]       page_addr_o
);

  localparam int unsigned FRAME_W = fpsa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int unsigned SLOT_W  = FRAME_W + 1;
  localparam int unsigned IDX_W   = $clog2(POOL_PAGES);
  localparam int unsigned CNT_W   = $clog2(POOL_PAGES + 1);

  fpsa_pkg::state_e            state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [FRAME_W-1:0]          f_q, f_d, last_q, last_d;
  logic [fpsa_pkg::SPAN_W-1:0] len_q, len_d, k_q, k_d;
  logic [CNT_W-1:0]            issue_q, issue_d;
  logic                        pend_q, pend_d;
  logic [IDX_W-1:0]            ridx_q, ridx_d;
  logic                        done_q, done_d;
  fpsa_pkg::status_e           status_q, status_d;
  logic [fpsa_pkg::ADDR_W-1:0] page_q, page_d;

  logic                        we, re;
  logic [IDX_W-1:0]            waddr, raddr;
  logic [SLOT_W-1:0]           wdata, rdata;
  logic                        rd_taken;
  logic [FRAME_W-1:0]          rd_frame;
  logic [FRAME_W-1:0]          in_frame, end_frame;
  logic [CNT_W-1:0]            cnt_m1;
  logic                        accept, full, empty, span_ok;
  fpsa_pkg::span_ctl_t         span_ctl;
  logic                        found;
  logic [IDX_W-1:0]            base_idx;
  logic [FRAME_W-1:0]          base_frame;

  assign accept    = start && !busy;
  assign busy      = (state_q != fpsa_pkg::S_IDLE);
  assign full      = (count_q == CNT_W'(POOL_PAGES));
  assign empty     = (count_q == '0);
  assign cnt_m1    = count_q - 1'b1;
  assign in_frame  = addr_i[fpsa_pkg::ADDR_W-1:PAGE_SHIFT];
  assign end_frame = end_addr_i[fpsa_pkg::ADDR_W-1:PAGE_SHIFT];
  assign rd_taken  = rdata[FRAME_W];
  assign rd_frame  = rdata[FRAME_W-1:0];
  assign span_ok   = (span_pages_i != '0) && (32'(span_pages_i) <= MAX_SPAN)
                     && (CNT_W'(span_pages_i) <= count_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      fpsa_pkg::S_IDLE: begin
        if (accept) begin
          case (fpsa_pkg::cmd_e'(cmd_i))
            fpsa_pkg::CMD_ALLOC:      state_d = empty ? fpsa_pkg::S_IDLE : fpsa_pkg::S_POP;
            fpsa_pkg::CMD_FREE:       state_d = fpsa_pkg::S_IDLE;
            fpsa_pkg::CMD_FREE_RANGE: state_d = fpsa_pkg::S_RANGE;
            fpsa_pkg::CMD_SPAN:       state_d = span_ok ? fpsa_pkg::S_SCAN : fpsa_pkg::S_IDLE;
            default:                  state_d = fpsa_pkg::S_IDLE;
          endcase
        end
      end
      fpsa_pkg::S_POP: begin
        if (!rd_taken || empty) begin
          state_d = fpsa_pkg::S_IDLE;
        end
      end
      fpsa_pkg::S_RANGE: begin
        if ((f_q >= last_q) || full) begin
          state_d = fpsa_pkg::S_IDLE;
        end
      end
      fpsa_pkg::S_SCAN: begin
        if (found) begin
          state_d = fpsa_pkg::S_MARK;
        end else if ((issue_q == count_q) && !pend_q) begin
          state_d = fpsa_pkg::S_IDLE;
        end
      end
      fpsa_pkg::S_MARK: begin
        if (k_q == len_q - 1'b1) begin
          state_d = fpsa_pkg::S_IDLE;
        end
      end
      default: state_d = fpsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_d  = count_q;
    f_d      = f_q;
    last_d   = last_q;
    len_d    = len_q;
    k_d      = k_q;
    issue_d  = issue_q;
    pend_d   = 1'b0;
    ridx_d   = ridx_q;
    done_d   = 1'b0;
    status_d = status_q;
    page_d   = page_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    re       = 1'b0;
    raddr    = '0;
    span_ctl = '{clr: 1'b0, vld: pend_q, len: len_q};
    case (state_q)
      fpsa_pkg::S_IDLE: begin
        if (accept) begin
          case (fpsa_pkg::cmd_e'(cmd_i))
            fpsa_pkg::CMD_ALLOC: begin
              if (empty) begin
                done_d   = 1'b1;
                status_d = fpsa_pkg::ST_NONE;
                page_d   = '0;
              end else begin
                count_d = cnt_m1;
                re      = 1'b1;
                raddr   = cnt_m1[IDX_W-1:0];
              end
            end
            fpsa_pkg::CMD_FREE: begin
              done_d = 1'b1;
              page_d = '0;
              if (full) begin
                status_d = fpsa_pkg::ST_FULL;
              end else begin
                status_d = fpsa_pkg::ST_OK;
                we       = 1'b1;
                waddr    = count_q[IDX_W-1:0];
                wdata    = {1'b0, in_frame};
                count_d  = count_q + 1'b1;
              end
            end
            fpsa_pkg::CMD_FREE_RANGE: begin
              f_d    = in_frame;
              last_d = end_frame;
            end
            fpsa_pkg::CMD_SPAN: begin
              if (!span_ok) begin
                done_d   = 1'b1;
                status_d = fpsa_pkg::ST_NONE;
                page_d   = '0;
              end else begin
                len_d        = span_pages_i;
                k_d          = '0;
                issue_d      = '0;
                span_ctl.clr = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      fpsa_pkg::S_POP: begin
        if (!rd_taken) begin
          done_d   = 1'b1;
          status_d = fpsa_pkg::ST_OK;
          page_d   = {rd_frame, {PAGE_SHIFT{1'b0}}};
        end else if (empty) begin
          done_d   = 1'b1;
          status_d = fpsa_pkg::ST_NONE;
          page_d   = '0;
        end else begin
          count_d = cnt_m1;
          re      = 1'b1;
          raddr   = cnt_m1[IDX_W-1:0];
        end
      end
      fpsa_pkg::S_RANGE: begin
        if (f_q >= last_q) begin
          done_d   = 1'b1;
          status_d = fpsa_pkg::ST_OK;
          page_d   = '0;
        end else if (full) begin
          done_d   = 1'b1;
          status_d = fpsa_pkg::ST_FULL;
          page_d   = '0;
        end else begin
          we      = 1'b1;
          waddr   = count_q[IDX_W-1:0];
          wdata   = {1'b0, f_q};
          count_d = count_q + 1'b1;
          f_d     = f_q + 1'b1;
        end
      end
      fpsa_pkg::S_SCAN: begin
        if (!found && (issue_q < count_q)) begin
          re      = 1'b1;
          raddr   = issue_q[IDX_W-1:0];
          ridx_d  = issue_q[IDX_W-1:0];
          issue_d = issue_q + 1'b1;
          pend_d  = 1'b1;
        end
        if (!found && (issue_q == count_q) && !pend_q) begin
          done_d   = 1'b1;
          status_d = fpsa_pkg::ST_NONE;
          page_d   = '0;
        end
      end
      fpsa_pkg::S_MARK: begin
        // run frames are consecutive, so the marked slot is rebuilt without a read
        we    = 1'b1;
        waddr = base_idx + IDX_W'(k_q);
        wdata = {1'b1, base_frame + FRAME_W'(k_q)};
        k_d   = k_q + 1'b1;
        if (k_q == len_q - 1'b1) begin
          done_d   = 1'b1;
          status_d = fpsa_pkg::ST_OK;
          page_d   = {base_frame, {PAGE_SHIFT{1'b0}}};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpsa_pkg::S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q      <= f_d;
    last_q   <= last_d;
    len_q    <= len_d;
    k_q      <= k_d;
    issue_q  <= issue_d;
    ridx_q   <= ridx_d;
    status_q <= status_d;
    page_q   <= page_d;
  end

  fpsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (POOL_PAGES)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  fpsa_span #(
    .IDX_W   (IDX_W),
    .FRAME_W (FRAME_W)
  ) u_span (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (span_ctl),
    .taken_i      (rd_taken),
    .frame_i      (rd_frame),
    .idx_i        (ridx_q),
    .found_o      (found),
    .base_idx_o   (base_idx),
    .base_frame_o (base_frame)
  );

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign page_addr_o = page_q;

endmodule

// ===== rtl/fpsa_chk.sv =====
// Port-level checker for free_page_stack_allocator, attached by bind.
// Depends on fpsa_pkg.
module fpsa_chk #(
  parameter int unsigned PAGE_SHIFT = fpsa_pkg::PAGE_SHIFT_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [fpsa_pkg::STATUS_W-1:0] status_o,
  input logic [fpsa_pkg::ADDR_W-1:0]   page_addr_o
);

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted item neither in progress nor finished");

  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result without an item");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != fpsa_pkg::ST_OK)) |-> (page_addr_o == '0))
    else $error("failure with nonzero page address");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == fpsa_pkg::ST_OK) || (status_o == fpsa_pkg::ST_NONE)
                || (status_o == fpsa_pkg::ST_FULL)))
    else $error("undefined status code");

  a_page_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (page_addr_o[PAGE_SHIFT-1:0] == '0))
    else $error("page address not aligned");

endmodule

bind free_page_stack_allocator fpsa_chk #(
  .PAGE_SHIFT (PAGE_SHIFT)
) u_fpsa_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .status_o    (status_o),
  .page_addr_o (page_addr_o)
);
